[rtl/pls_pkg.sv]
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants for the positional list store: action and
// status codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

    // Field widths of one word
    localparam int DATA_W      = 32;
    localparam int POS_W       = 5;
    localparam int CNT_OUT_W   = 5;
    localparam int ACT_W       = 3;
    localparam int STAT_W      = 2;
    localparam int TDATA_W     = 40;

    // Most words emitted by one read-all
    localparam int MAX_RESULTS = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_END   = 3'd0,
        ACT_INS_BEGIN = 3'd1,
        ACT_INS_POS   = 3'd2,
        ACT_DEL_END   = 3'd3,
        ACT_DEL_BEGIN = 3'd4,
        ACT_DEL_POS   = 3'd5,
        ACT_READ_ALL  = 3'd6
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic op_exec;   // apply the accepted action and load its result
        logic rd_clear;  // start a read-all pass
        logic rd_step;   // rotate the list by one cell and advance the index
        logic rd_load;   // load the head cell into the output register
    } pls_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;    // output register can take a word this cycle
        logic count_zero;  // list is empty
        logic rd_emit;     // current read index still produces a word
        logic rd_done;     // current read index is the last cell
    } pls_stat_t;

endpackage : pls_pkg

`default_nettype wire

[rtl/positional_list_store.sv]
// Non-read word: the result is loaded into the output register at the accepting edge;
// with a free output the next word can be taken in the following cycle.
// Read-all: a setup step clears the read index, then count rotation steps of one cell
// each; min(count, 16) words come out, the first once the controller is in its read
// state, then one word per cycle; output stalls hold the rotation. One word is in work at a time.
// Reset clears controller state, count and output valid; the cells are not reset.
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of up to DEPTH signed 32-bit values with positional insert,
// delete and in-order read-out, on stream ports.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store #(
    parameter int DEPTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] value, [36:32] position, [39:37] zero
    input  wire logic [pls_pkg::TDATA_W-1:0]    s_axis_tdata,
    // [2:0] action
    input  wire logic [pls_pkg::ACT_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [31:0] item_value, [36:32] entry_count, [39:37] zero
    output logic [pls_pkg::TDATA_W-1:0]         m_axis_tdata,
    // [1:0] status
    output logic [pls_pkg::STAT_W-1:0]          m_axis_tuser,
    output logic                                m_axis_tlast
);
    import pls_pkg::*;

    pls_cmd_t  ctl_cmd;
    pls_stat_t dp_stat;
    action_t   act;

    assign act = action_t'(s_axis_tuser);

    pls_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .act           (act),
        .stat          (dp_stat),
        .cmd           (ctl_cmd)
    );

    pls_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (ctl_cmd),
        .stat          (dp_stat),
        .act           (act),
        .in_value      (s_axis_tdata[DATA_W-1:0]),
        .in_position   (s_axis_tdata[DATA_W+POS_W-1:DATA_W]),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // Input is never taken while a read-all rotation runs
    a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.rd_step |-> !s_axis_tready)
        else $error("input accepted during read-all");

    // At most one datapath action per cycle
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl_cmd.op_exec, ctl_cmd.rd_clear, ctl_cmd.rd_step}))
        else $error("conflicting datapath commands");

    // Error results are single words with a zero value
    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |->
        (m_axis_tlast && (m_axis_tdata[DATA_W-1:0] == '0)))
        else $error("error result not a single zero word");

    // A full report carries the full count
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_FULL)) |->
        (m_axis_tdata[DATA_W+CNT_OUT_W-1:DATA_W] == CNT_OUT_W'(DEPTH)))
        else $error("full status with wrong count");
`endif

endmodule : positional_list_store

`default_nettype wire

[rtl/pls_ctrl.sv]
// ----------------------------------------------------------------------------
// pls_ctrl
// Controller of the positional list store: accepts one word at a time and
// sequences the read-all rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire pls_pkg::action_t  act,
    input  wire pls_pkg::pls_stat_t stat,
    output pls_pkg::pls_cmd_t      cmd
);
    import pls_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = (state_reg == S_IDLE) && s_axis_tvalid && stat.out_free;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (act == ACT_READ_ALL) && !stat.count_zero)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (stat.rd_done && (!stat.rd_emit || stat.out_free))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = stat.out_free;
                if (accept)
                begin
                    if ((act == ACT_READ_ALL) && !stat.count_zero)
                    begin
                        cmd.rd_clear = 1'b1;
                    end
                    else
                    begin
                        cmd.op_exec = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                // Past the last emitted word step on; else hold while the output word is still waiting
                if (!stat.rd_emit)
                begin
                    cmd.rd_step = 1'b1;
                end
                else if (stat.out_free)
                begin
                    cmd.rd_step = 1'b1;
                    cmd.rd_load = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule : pls_ctrl

`default_nettype wire

[rtl/pls_dp.sv]
// ----------------------------------------------------------------------------
// pls_dp
// Datapath of the positional list store: a row of shifting cells, the
// element count, the read index and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_dp #(
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire pls_pkg::pls_cmd_t                cmd,
    output pls_pkg::pls_stat_t                    stat,
    input  wire pls_pkg::action_t                 act,
    input  wire logic [pls_pkg::DATA_W-1:0]       in_value,
    input  wire logic [pls_pkg::POS_W-1:0]        in_position,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [pls_pkg::TDATA_W-1:0]           m_axis_tdata,
    output logic [pls_pkg::STAT_W-1:0]            m_axis_tuser,
    output logic                                  m_axis_tlast
);
    import pls_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int W  = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [W-1:0] ONE_W   = W'(1);
    localparam logic [W-1:0] DEPTH_W = W'(DEPTH);
    localparam logic [W-1:0] MAX_W   = W'(MAX_RESULTS);

    logic [DATA_W-1:0]    cell_reg  [DEPTH];
    logic [DATA_W-1:0]    cell_next [DEPTH];
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [CW-1:0]        rd_idx_reg;
    logic [CW-1:0]        rd_idx_next;

    logic                 out_valid_reg;
    logic [STAT_W-1:0]    out_status_reg;
    logic [DATA_W-1:0]    out_value_reg;
    logic [CNT_OUT_W-1:0] out_count_reg;
    logic                 out_last_reg;

    logic [W-1:0]         cnt_w;
    logic [W-1:0]         pos_w;
    logic [W-1:0]         rd_w;
    logic [W-1:0]         k_w;
    logic                 full;
    logic                 empty;
    logic                 do_ins;
    logic                 do_del;
    status_t              op_status;
    logic                 rd_last;

    assign cnt_w = W'(count_reg);
    assign pos_w = W'(in_position);
    assign rd_w  = W'(rd_idx_reg);
    assign full  = (cnt_w == DEPTH_W);
    assign empty = (cnt_w == '0);

    // Decode the action: status, target cell and list change
    always_comb
    begin
        op_status = ST_OK;
        k_w       = '0;
        do_ins    = 1'b0;
        do_del    = 1'b0;
        unique case (act)
            ACT_INS_END, ACT_INS_BEGIN:
            begin
                k_w       = (act == ACT_INS_END) ? cnt_w : '0;
                op_status = full ? ST_FULL : ST_OK;
                do_ins    = !full;
            end
            ACT_INS_POS:
            begin
                k_w = pos_w - ONE_W;
                if ((pos_w == '0) || (pos_w > cnt_w + ONE_W))
                begin
                    op_status = ST_INVALID;
                end
                else
                begin
                    op_status = full ? ST_FULL : ST_OK;
                    do_ins    = !full;
                end
            end
            ACT_DEL_END, ACT_DEL_BEGIN:
            begin
                k_w       = (act == ACT_DEL_END) ? (cnt_w - ONE_W) : '0;
                op_status = empty ? ST_EMPTY : ST_OK;
                do_del    = !empty;
            end
            ACT_DEL_POS:
            begin
                k_w = pos_w - ONE_W;
                if ((pos_w == '0) || (pos_w > cnt_w))
                begin
                    op_status = ST_INVALID;
                end
                else
                begin
                    do_del = 1'b1;
                end
            end
            ACT_READ_ALL:
            begin
                // Reaches here only for an empty list
                op_status = ST_EMPTY;
            end
            default:
            begin
                op_status = ST_OK;
            end
        endcase
    end

    // Per-cell shift and rotate selection
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == DEPTH - 1) ? g : g + 1;
        localparam logic [W-1:0] G_W = W'(g);

        always_comb
        begin
            cell_next[g] = cell_reg[g];
            priority if (cmd.op_exec && do_ins && (G_W == k_w))
            begin
                cell_next[g] = in_value;
            end
            else if (cmd.op_exec && do_ins && (G_W > k_w))
            begin
                cell_next[g] = cell_reg[PREV];
            end
            else if (cmd.op_exec && do_del && (G_W >= k_w))
            begin
                cell_next[g] = cell_reg[NEXT];
            end
            else if (cmd.rd_step && (G_W == cnt_w - ONE_W))
            begin
                cell_next[g] = cell_reg[0];
            end
            else if (cmd.rd_step && (G_W < cnt_w - ONE_W))
            begin
                cell_next[g] = cell_reg[NEXT];
            end
        end
    end

    // Hold the cells; contents are defined only once written
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    // Count and read index
    always_comb
    begin
        count_next = count_reg;
        if (cmd.op_exec && do_ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.op_exec && do_del)
        begin
            count_next = count_reg - CW'(1);
        end

        rd_idx_next = rd_idx_reg;
        if (cmd.rd_clear)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.rd_step)
        begin
            rd_idx_next = rd_idx_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    // Status back to the controller
    assign rd_last         = (rd_w == cnt_w - ONE_W) || (rd_w == MAX_W - ONE_W);
    assign stat.out_free   = !out_valid_reg || m_axis_tready;
    assign stat.count_zero = empty;
    assign stat.rd_emit    = (rd_w < MAX_W);
    assign stat.rd_done    = (rd_w == cnt_w - ONE_W);

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op_exec || cmd.rd_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.op_exec)
        begin
            out_status_reg <= op_status;
            out_value_reg  <= '0;
            out_count_reg  <= CNT_OUT_W'(count_next);
            out_last_reg   <= 1'b1;
        end
        else if (cmd.rd_load)
        begin
            out_status_reg <= ST_OK;
            out_value_reg  <= cell_reg[0];
            out_count_reg  <= CNT_OUT_W'(count_reg);
            out_last_reg   <= rd_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W - DATA_W - CNT_OUT_W){1'b0}}, out_count_reg,
                            out_value_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule : pls_dp

`default_nettype wire

[tb/positional_list_store_tb.sv]
// ----------------------------------------------------------------------------
// positional_list_store_tb
// Self-checking bench for the positional list store. A queue of list
// commands feeds a stream driver. A monitor mirrors every accepted command
// in a local list model and checks each result word against it, field by
// field. Random stall bursts hit both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pls_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int QUIET_TAIL = 60;
    localparam int RANDOM_CMDS = 450;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  position;
        logic              drain_first;  // hold until every result is back
    } list_cmd_t;

    typedef struct packed {
        status_t              status;
        logic [DATA_W-1:0]    value;
        logic [CNT_OUT_W-1:0] count;
        logic                 last;
    } list_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata = '0;
    logic [ACT_W-1:0]     s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [STAT_W-1:0]    m_axis_tuser;
    logic                 m_axis_tlast;

    list_cmd_t  cmd_q[$];
    list_word_t result_q[$];
    list_cmd_t  cur_cmd;

    // Local list model
    logic [DATA_W-1:0] list_cells[LIST_DEPTH];
    int unsigned       list_len = 0;

    // Length seen by the command generator, used to aim positions
    int unsigned gen_len = 0;

    int errors = 0;
    int words_in = 0;
    int words_sent = 0;
    int results_checked = 0;
    int reads_nonempty = 0;
    int full_hits = 0;
    int invalid_hits = 0;
    int empty_hits = 0;
    int src_gap = 0;
    int snk_gap = 0;
    bit src_bursty = 1'b1;
    bit snk_bursty = 1'b1;

    positional_list_store #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic list_word_t make_word(status_t st, logic [DATA_W-1:0] val,
                                             int unsigned cnt, logic lst);
        list_word_t w;
        w.status = st;
        w.value  = val;
        w.count  = CNT_OUT_W'(cnt);
        w.last   = lst;
        return w;
    endfunction

    // Apply one command to the list model and queue the words it produces
    task automatic predict_list_step(input list_cmd_t c);
        int unsigned slot;
        int unsigned n;
        status_t     st;
        bit          streamed;
        st = ST_OK;
        streamed = 1'b0;
        slot = 0;
        case (c.action)
            ACT_INS_END, ACT_INS_BEGIN, ACT_INS_POS:
            begin
                if (c.action == ACT_INS_POS &&
                    (c.position < 1 || c.position > list_len + 1))
                    st = ST_INVALID;
                else if (list_len >= LIST_DEPTH)
                    st = ST_FULL;
                else
                begin
                    if (c.action == ACT_INS_END)
                        slot = list_len;
                    else if (c.action == ACT_INS_POS)
                        slot = c.position - 1;
                    for (int i = list_len; i > slot; i--)
                        list_cells[i] = list_cells[i - 1];
                    list_cells[slot] = c.value;
                    list_len++;
                end
            end
            ACT_DEL_END, ACT_DEL_BEGIN, ACT_DEL_POS:
            begin
                if (c.action == ACT_DEL_POS) begin
                    if (c.position < 1 || c.position > list_len)
                        st = ST_INVALID;
                    else
                        slot = c.position - 1;
                end
                else if (list_len == 0)
                    st = ST_EMPTY;
                else if (c.action == ACT_DEL_END)
                    slot = list_len - 1;
                if (st == ST_OK)
                begin
                    for (int i = slot; i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i + 1];
                    list_len--;
                end
            end
            ACT_READ_ALL:
            begin
                if (list_len != 0)
                begin
                    streamed = 1'b1;
                    reads_nonempty++;
                    n = (list_len < MAX_RESULTS) ? list_len : MAX_RESULTS;
                    for (int i = 0; i < n; i++)
                        result_q.push_back(make_word(ST_OK, list_cells[i], list_len,
                                                     (i + 1 == n)));
                end
                else
                    st = ST_EMPTY;
            end
            default: ;
        endcase
        if (!streamed)
            result_q.push_back(make_word(st, '0, list_len, 1'b1));
        if (st == ST_FULL)
            full_hits++;
        if (st == ST_INVALID)
            invalid_hits++;
        if (st == ST_EMPTY)
            empty_hits++;
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
            errors++;
        end
    endtask

    // Queue one command, tracking the length it should leave behind
    task automatic add_cmd(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val,
                           input logic [POS_W-1:0] pos, input logic drain);
        list_cmd_t c;
        c.action = act;
        c.value = val;
        c.position = pos;
        c.drain_first = drain;
        cmd_q.push_back(c);
        case (act)
            ACT_INS_END, ACT_INS_BEGIN:
                if (gen_len < LIST_DEPTH)
                    gen_len++;
            ACT_INS_POS:
                if (pos >= 1 && pos <= gen_len + 1 && gen_len < LIST_DEPTH)
                    gen_len++;
            ACT_DEL_END, ACT_DEL_BEGIN:
                if (gen_len != 0)
                    gen_len--;
            ACT_DEL_POS:
                if (pos >= 1 && pos <= gen_len)
                    gen_len--;
            default: ;
        endcase
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Drive command words; pull the next one once the current word is taken
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || words_in == words_sent))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (cmd_q.size() == 0 ||
                     (cmd_q[0].drain_first && result_q.size() != 0))
                s_axis_tvalid <= 1'b0;
            else if (src_bursty && cmd_q.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
            begin
                src_gap = $urandom_range(0, 10);
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                cur_cmd = cmd_q.pop_front();
                words_sent++;
                s_axis_tdata  <= {3'b000, cur_cmd.position, cur_cmd.value};
                s_axis_tuser  <= cur_cmd.action;
                s_axis_tvalid <= 1'b1;
                if ($urandom_range(0, 19) == 0)
                    src_bursty = !src_bursty;
            end
        end
    end

    // Stall the result side in random bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (snk_gap > 0)
        begin
            snk_gap--;
            m_axis_tready <= 1'b0;
        end
        else if (snk_bursty && cmd_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
        begin
            snk_gap = $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 39) == 0)
                snk_bursty = !snk_bursty;
        end
    end

    // Check result words, then fold in the command taken at this edge
    always @(posedge clk)
    begin
        list_word_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual status %0d data %h last %b",
                             $realtime, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    errors++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("status", 32'(want.status), 32'(m_axis_tuser));
                    check_field("item_value", want.value, m_axis_tdata[31:0]);
                    check_field("entry_count", 32'(want.count), 32'(m_axis_tdata[36:32]));
                    check_field("last", 32'(want.last), 32'(m_axis_tlast));
                    results_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_list_step(cur_cmd);
                words_in++;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("positional_list_store_tb NOT OK");
        $finish;
    end

    initial
    begin
        int unsigned roll;
        int unsigned ins_pct;
        int unsigned kind;
        logic [POS_W-1:0] pos;

        // Directed: empty list cases, value extremes, position bounds
        add_cmd(ACT_READ_ALL, '0, '0, 1'b0);
        add_cmd(ACT_DEL_END, '0, '0, 1'b0);
        add_cmd(ACT_DEL_BEGIN, '0, '0, 1'b0);
        add_cmd(ACT_DEL_POS, '0, 5'd0, 1'b0);
        add_cmd(ACT_DEL_POS, '0, 5'd1, 1'b0);
        add_cmd(ACT_INS_POS, 32'h1234_5678, 5'd0, 1'b0);
        add_cmd(ACT_INS_POS, 32'h1234_5678, 5'd2, 1'b0);
        add_cmd(ACT_INS_END, 32'h7FFF_FFFF, '0, 1'b0);
        add_cmd(ACT_INS_BEGIN, 32'h8000_0000, '0, 1'b0);
        add_cmd(ACT_INS_POS, 32'hFFFF_FFFF, 5'd2, 1'b0);
        add_cmd(ACT_INS_POS, 32'h0000_0000, 5'd4, 1'b0);
        add_cmd(ACT_INS_POS, 32'hA5A5_5A5A, 5'd1, 1'b0);
        add_cmd(ACT_READ_ALL, '0, '0, 1'b0);
        add_cmd(ACT_DEL_POS, '0, 5'd6, 1'b0);
        add_cmd(ACT_DEL_POS, '0, 5'd31, 1'b0);
        add_cmd(ACT_INS_POS, 32'h5A5A_A5A5, 5'd31, 1'b0);
        add_cmd(ACT_UNUSED, 32'hDEAD_BEEF, 5'd31, 1'b0);
        add_cmd(ACT_DEL_POS, '0, 5'd5, 1'b0);
        add_cmd(ACT_DEL_POS, '0, 5'd2, 1'b0);
        add_cmd(ACT_DEL_END, '0, '0, 1'b0);
        add_cmd(ACT_DEL_BEGIN, '0, '0, 1'b0);
        add_cmd(ACT_READ_ALL, '0, '0, 1'b0);
        add_cmd(ACT_DEL_POS, '0, 5'd1, 1'b0);
        add_cmd(ACT_READ_ALL, '0, '0, 1'b0);

        // Random: phases that fill, drain or mix the list
        ins_pct = 44;
        for (int k = 0; k < RANDOM_CMDS; k++)
        begin
            if (k % 40 == 0)
                case ($urandom_range(0, 2))
                    0: ins_pct = 66;
                    1: ins_pct = 22;
                    default: ins_pct = 44;
                endcase
            roll = $urandom_range(0, 99);
            kind = $urandom_range(0, 2);
            if (roll < 10)
                add_cmd(ACT_READ_ALL, $urandom(), 5'($urandom()), (k % 100 == 50));
            else if (roll < 12)
                add_cmd(ACT_UNUSED, $urandom(), 5'($urandom()), (k % 100 == 50));
            else if (roll < 12 + ins_pct)
            begin
                if ($urandom_range(0, 4) == 0)
                    pos = 5'($urandom_range(0, 31));
                else
                    pos = 5'($urandom_range(1, gen_len + 1));
                case (kind)
                    0: add_cmd(ACT_INS_END, pick_value(), pos, (k % 100 == 50));
                    1: add_cmd(ACT_INS_BEGIN, pick_value(), pos, (k % 100 == 50));
                    default: add_cmd(ACT_INS_POS, pick_value(), pos, (k % 100 == 50));
                endcase
            end
            else
            begin
                if ($urandom_range(0, 4) == 0 || gen_len == 0)
                    pos = 5'($urandom_range(0, 31));
                else
                    pos = 5'($urandom_range(1, gen_len));
                case (kind)
                    0: add_cmd(ACT_DEL_END, $urandom(), pos, (k % 100 == 50));
                    1: add_cmd(ACT_DEL_BEGIN, $urandom(), pos, (k % 100 == 50));
                    default: add_cmd(ACT_DEL_POS, $urandom(), pos, (k % 100 == 50));
                endcase
            end
        end
        add_cmd(ACT_READ_ALL, '0, '0, 1'b0);

        // Hold reset, then release at a falling edge
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every command to go in and every word to come back
        while (cmd_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d commands, checked %0d words, %0d non-empty read-alls.",
                 words_in, results_checked, reads_nonempty);
        $display("Status hits: %0d full, %0d invalid position, %0d empty.",
                 full_hits, invalid_hits, empty_hits);
        if (errors == 0)
            $display("positional_list_store_tb OK");
        else
            $display("positional_list_store_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
